>>> hdl/ppioa_pkg.sv
// ppioa_pkg: shared constants and types for the per-process io accounting table
// no dependencies
`timescale 1ns / 1ps
package ppioa_pkg;
   localparam int ENTRIES   = 32;
   localparam int TOP_COUNT = 16;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CTR_ADR_W = $clog2(ENTRIES * 4);
   localparam int KEY_W     = 23 + 64;

   localparam logic [1:0] OP_ACCOUNT = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_DRAIN   = 2'd2;

   localparam logic [1:0] REC_ACK    = 2'd0;
   localparam logic [1:0] REC_ENTRY  = 2'd1;
   localparam logic [1:0] REC_OTHERS = 2'd2;
   localparam logic [1:0] REC_END    = 2'd3;

   localparam logic [2:0] KIND_FLUSH = 3'd2;

   localparam logic [0:0] CSR_ENABLE = 1'd0;
   localparam logic [0:0] CSR_WINDOW = 1'd1;

   localparam logic [22:0] OTHERS_ID  = 23'd99999;
   localparam logic [13:0] WINDOW_MAX = 14'd10000;
   localparam logic [13:0] WINDOW_RST = 14'd5000;

   typedef struct packed {
      logic [1:0]  op;
      logic        is_internal;
      logic [2:0]  req_kind;
      logic [31:0] xfer_bytes;
      logic [22:0] proc_id;
      logic [63:0] proc_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [22:0] rec_proc_id;
      logic [63:0] read_total;
      logic [63:0] write_total;
      logic [63:0] flush_total;
      logic [63:0] discard_total;
      logic [63:0] all_bytes;
      logic        last;
   } rsp_type;
endpackage

>>> hdl/ppioa_if.sv
// ppioa_if: valid/ready channel carrying one payload item
// depends on ppioa_pkg for payload types
`timescale 1ns / 1ps
interface ppioa_req_if;
   logic                valid;
   logic                ready;
   ppioa_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ppioa_rsp_if;
   logic                valid;
   logic                ready;
   ppioa_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ppioa_ram.sv
// ppioa_ram: generic single-port-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ppioa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hdl/per_process_io_accounting_table.sv
// per_process_io_accounting_table: top level, sequencer around key and counter rams
// depends on ppioa_pkg, ppioa_if, ppioa_ram
//
// usage
//  - req channel takes one item: account, tick or drain; csr port writes enable (index 0)
//    and window length (index 1, clamped to 10000) while idle: kept by the user, not the block
//  - rsp channel gives one acknowledge per non-drain item, and for a drain
//    one record per table entry and then an others or end record; last marks
//    the final record of an item
//  - one item at a time: an account runs a serial key search, one ram read per
//    entry, then read-modify-write of one counter
//  - a drain with more than TOP_COUNT entries runs TOP_COUNT max-search passes,
//    each reading both priority counters of every entry, then emits the rest
//    newest first
//  - records wait in an output register; while the receiver stalls the
//    sequencer simply holds, nothing is lost
//  - reset empties the table, clears others and byte total, marks the window
//    expired (nothing tabled until the first drain); rams need no clearing
//    since only entries below the fill count are read
`timescale 1ns / 1ps
module per_process_io_accounting_table (
   input  logic              clock,
   input  logic              reset,
   ppioa_req_if.sink         req,
   ppioa_rsp_if.source       rsp,
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  logic [13:0]       csr_wr_data
);
   localparam int IW = ppioa_pkg::IDX_W;
   localparam int CW = ppioa_pkg::CNT_W;
   localparam int AW = ppioa_pkg::CTR_ADR_W;
   localparam int ENTRIES_W = ppioa_pkg::ENTRIES;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SRCH   = 4'd1;  // issue key read
   localparam logic [3:0] S_SCMP   = 4'd2;  // compare key
   localparam logic [3:0] S_UPD    = 4'd3;  // counter read returned, write back
   localparam logic [3:0] S_NEW    = 4'd4;  // write four counters of new entry: item bytes in its kind, zero elsewhere
   localparam logic [3:0] S_PRD    = 4'd5;  // priority pass: issue read
   localparam logic [3:0] S_PWAIT  = 4'd6;  // priority pass: latch counter
   localparam logic [3:0] S_EMIT   = 4'd7;  // emission: issue read
   localparam logic [3:0] S_EWAIT  = 4'd8;  // emission: latch counter / key
   localparam logic [3:0] S_OUT    = 4'd9;  // wait for output register free
   localparam logic [3:0] S_RMW    = 4'd10; // counter read latency

   // config
   logic        enable_ff;
   logic [13:0] window_ms_ff;

   // state
   logic [CW-1:0]  count_ff;
   logic [63:0]    others_ff [4];
   logic [63:0]    byte_total_ff;
   logic [13:0]    window_left_ff;
   logic           expired_ff;
   logic [ENTRIES_W-1:0] used_ff;

   logic [3:0]     state_ff;
   ppioa_pkg::req_type item_ff;
   logic [IW:0]    idx_ff;     // entry walk, signed-free: counts down or up
   logic [1:0]     sub_ff;     // counter within entry
   logic [63:0]    acc_ff;     // read counter / priority partial
   logic [63:0]    best_ff;
   logic [IW-1:0]  pick_ff;
   logic           pick_ok_ff;
   logic [CW-1:0]  pass_ff;
   logic           top_ff;     // in top selection phase
   ppioa_pkg::rsp_type rec_ff, rec_in;
   logic [63:0]    ctr_ff [4];

   // output register
   logic               ov_ff;
   ppioa_pkg::rsp_type od_ff, od_in;

   // rams
   logic              key_we;
   logic [IW-1:0]     key_wa, key_ra;
   logic [ppioa_pkg::KEY_W-1:0] key_wd, key_rd;
   logic              ctr_we;
   logic [AW-1:0]     ctr_wa, ctr_ra;
   logic [63:0]       ctr_wd, ctr_rd;

   ppioa_ram #(.WIDTH(ppioa_pkg::KEY_W), .DEPTH(ppioa_pkg::ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(key_ra), .rd_data(key_rd));
   ppioa_ram #(.WIDTH(64), .DEPTH(ppioa_pkg::ENTRIES * 4)) u_ctr_ram (
      .clock(clock), .wr_en(ctr_we), .wr_addr(ctr_wa), .wr_data(ctr_wd),
      .rd_addr(ctr_ra), .rd_data(ctr_rd));

   wire [IW-1:0] idx_lo = idx_ff[IW-1:0];
   wire          key_hit = (key_rd == {item_ff.proc_id, item_ff.proc_start});
   wire          do_table = item_ff.is_internal && enable_ff && !expired_ff
                            && (item_ff.req_kind <= 3'd3);

   assign req.ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.data  = od_ff;

   // ram addressing, combinational from state
   always_comb begin
      key_we = 1'b0;
      key_wa = count_ff[IW-1:0];
      key_wd = {item_ff.proc_id, item_ff.proc_start};
      key_ra = idx_lo;
      ctr_we = 1'b0;
      ctr_wa = {idx_lo, sub_ff};
      ctr_wd = 64'd0;
      ctr_ra = {idx_lo, sub_ff};
      unique case (state_ff)
         S_UPD: begin
            ctr_we = 1'b1;
            ctr_wa = {idx_lo, item_ff.req_kind[1:0]};
            ctr_wd = ctr_rd + ((item_ff.req_kind == ppioa_pkg::KIND_FLUSH) ?
                               64'd1 : {32'd0, item_ff.xfer_bytes});
         end
         S_NEW: begin
            ctr_we = 1'b1;
            ctr_wa = {count_ff[IW-1:0], sub_ff};
            ctr_wd = (sub_ff == item_ff.req_kind[1:0]) ?
                     {32'd0, item_ff.xfer_bytes} : 64'd0;
            key_we = (sub_ff == 2'd3);
         end
         S_RMW: ctr_ra = {idx_lo, item_ff.req_kind[1:0]};
         S_SRCH, S_SCMP: ctr_ra = {idx_lo, item_ff.req_kind[1:0]};
         // keep the discard counter on the read port while the record waits
         S_OUT: ctr_ra = {idx_lo, 2'd3};
         default: ;
      endcase
   end

   // closing record of a drain: others bucket or plain end
   always_comb begin
      rec_in      = '0;
      rec_in.last = 1'b1;
      if (others_ff[0] + others_ff[1] != 64'd0) begin
         rec_in.record_kind   = ppioa_pkg::REC_OTHERS;
         rec_in.rec_proc_id   = ppioa_pkg::OTHERS_ID;
         rec_in.read_total    = others_ff[0];
         rec_in.write_total   = others_ff[1];
         rec_in.flush_total   = others_ff[2];
         rec_in.discard_total = others_ff[3];
      end else begin
         rec_in.record_kind = ppioa_pkg::REC_END;
      end
   end

   // record loaded into the output register
   always_comb begin
      od_in           = rec_ff;
      od_in.all_bytes = byte_total_ff;
      if (item_ff.op != ppioa_pkg::OP_DRAIN) begin
         od_in.record_kind = ppioa_pkg::REC_ACK;
         od_in.last        = 1'b1;
      end else if (!rec_ff.last) begin
         od_in.record_kind   = ppioa_pkg::REC_ENTRY;
         od_in.rec_proc_id   = key_rd[86:64];
         od_in.read_total    = ctr_ff[0];
         od_in.write_total   = ctr_ff[1];
         od_in.flush_total   = ctr_ff[2];
         od_in.discard_total = ctr_rd;
         od_in.last          = 1'b0;
      end
   end

   // csr writes and sequencer; in emission the next pick is the newest unused entry below idx
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         window_ms_ff   <= ppioa_pkg::WINDOW_RST;
         count_ff       <= '0;
         for (int k = 0; k < 4; k++) others_ff[k] <= 64'd0;
         byte_total_ff  <= 64'd0;
         window_left_ff <= 14'd0;
         expired_ff     <= 1'b1;
         state_ff       <= S_IDLE;
         ov_ff          <= 1'b0;
         used_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ppioa_pkg::CSR_ENABLE: enable_ff <= csr_wr_data[0];
               ppioa_pkg::CSR_WINDOW: window_ms_ff <=
                  (csr_wr_data > ppioa_pkg::WINDOW_MAX) ? ppioa_pkg::WINDOW_MAX
                                                       : csr_wr_data;
               default: ;
            endcase
         end
         if (ov_ff && rsp.ready) ov_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: if (req.valid && !ov_ff) begin
               item_ff <= req.data;
               rec_ff  <= '0;
               if (req.data.op == ppioa_pkg::OP_DRAIN) begin
                  used_ff    <= '0;
                  pass_ff    <= '0;
                  top_ff     <= (count_ff > CW'(ppioa_pkg::TOP_COUNT));
                  idx_ff     <= (IW+1)'(count_ff);
                  best_ff    <= 64'd0;
                  pick_ok_ff <= 1'b0;
                  sub_ff     <= 2'd0;
                  state_ff   <= (count_ff > CW'(ppioa_pkg::TOP_COUNT)) ? S_PRD : S_EMIT;
               end else begin
                  if (req.data.op == ppioa_pkg::OP_TICK) begin
                     if (window_left_ff != 14'd0) window_left_ff <= window_left_ff - 14'd1;
                     else expired_ff <= 1'b1;
                  end
                  if (req.data.op == ppioa_pkg::OP_ACCOUNT && req.data.is_internal)
                     byte_total_ff <= byte_total_ff + {32'd0, req.data.xfer_bytes};
                  idx_ff   <= '0;
                  state_ff <= (req.data.op == ppioa_pkg::OP_ACCOUNT) ? S_SRCH : S_OUT;
               end
            end
            // account: serial key search
            S_SRCH: begin
               if (!do_table) state_ff <= S_OUT;
               else if (idx_ff == (IW+1)'(count_ff)) begin
                  if (count_ff == CW'(ppioa_pkg::ENTRIES)) begin
                     others_ff[item_ff.req_kind[1:0]] <=
                        others_ff[item_ff.req_kind[1:0]] + {32'd0, item_ff.xfer_bytes};
                     state_ff <= S_OUT;
                  end else begin
                     sub_ff   <= 2'd0;
                     state_ff <= S_NEW;
                  end
               end else state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (key_hit) state_ff <= S_RMW;
               else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SRCH;
               end
            end
            S_RMW: state_ff <= S_UPD;
            S_UPD: state_ff <= S_OUT;
            S_NEW: begin
               sub_ff <= sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_OUT;
               end
            end
            // top selection: walk entries newest first, sum read + 2*write
            S_PRD: begin
               if (idx_ff == '0) begin
                  // pass done
                  if (pick_ok_ff) begin
                     used_ff[pick_ff] <= 1'b1;
                     idx_ff   <= {1'b0, pick_ff} + 1'b1;
                     sub_ff   <= 2'd0;
                     top_ff   <= 1'b1;
                     state_ff <= S_EMIT;
                  end else begin
                     top_ff   <= 1'b0;
                     idx_ff   <= (IW+1)'(count_ff);
                     state_ff <= S_EMIT;
                  end
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  sub_ff   <= 2'd0;
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               // reads of sub 0 then sub 1 for entry idx
               if (sub_ff == 2'd0) begin
                  sub_ff   <= 2'd1;
                  state_ff <= S_PWAIT;
                  acc_ff   <= 64'd0;
               end else if (sub_ff == 2'd1) begin
                  acc_ff <= ctr_rd;       // read counter
                  sub_ff <= 2'd2;
               end else begin
                  if (!used_ff[idx_lo] && (acc_ff + {ctr_rd[62:0], 1'b0}) > best_ff) begin
                     best_ff    <= acc_ff + {ctr_rd[62:0], 1'b0};
                     pick_ff    <= idx_lo;
                     pick_ok_ff <= 1'b1;
                  end
                  sub_ff   <= 2'd0;
                  state_ff <= S_PRD;
               end
            end
            // emission: idx points one above the entry; read four counters
            S_EMIT: begin
               if (top_ff) begin
                  state_ff <= S_EWAIT;
                  idx_ff   <= idx_ff - 1'b1;
               end else if (idx_ff == '0) begin
                  rec_ff   <= rec_in;
                  count_ff <= '0;
                  for (int k = 0; k < 4; k++) others_ff[k] <= 64'd0;
                  window_left_ff <= window_ms_ff;
                  expired_ff     <= 1'b0;
                  state_ff <= S_OUT;
               end else if (used_ff[idx_ff[IW-1:0] - 1'b1]) begin
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= S_EWAIT;
               end
               sub_ff <= 2'd0;
            end
            S_EWAIT: begin
               // sub_ff walks 0..3 issuing reads; data lands in the next cycle
               sub_ff <= sub_ff + 2'd1;
               if (sub_ff != 2'd0) ctr_ff[sub_ff - 2'd1] <= ctr_rd;
               if (sub_ff == 2'd3) state_ff <= S_OUT;
               if (sub_ff == 2'd3) begin
                  acc_ff <= 64'd1; // marks entry record pending last read
               end
            end
            S_OUT: begin
               if (!ov_ff) begin
                  ov_ff <= 1'b1;
                  od_ff <= od_in;
                  if (item_ff.op != ppioa_pkg::OP_DRAIN) begin
                     state_ff <= S_IDLE;
                  end else if (rec_ff.last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     pass_ff <= pass_ff + 1'b1;
                     if (top_ff && (pass_ff + 1'b1 < CW'(ppioa_pkg::TOP_COUNT))) begin
                        idx_ff     <= (IW+1)'(count_ff);
                        best_ff    <= 64'd0;
                        pick_ok_ff <= 1'b0;
                        state_ff   <= S_PRD;
                     end else begin
                        if (top_ff) idx_ff <= (IW+1)'(count_ff);
                        top_ff   <= 1'b0;
                        state_ff <= S_EMIT;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> tb/sv/ppioa_checker.sv
// ppioa_checker: watches the req and rsp channels, predicts the accounting table's records
// and compares them; depends on ppioa_pkg and ppioa_if
`timescale 1ns / 1ps
module ppioa_checker
   import ppioa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ppioa_req_if        req,
   ppioa_rsp_if        rsp,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [13:0] csr_wr_data,
   output int          fail_count,
   output int          records_pending
);
   // predicted state of the table
   logic        en_q;
   logic [13:0] win_len;
   logic [22:0] key_id [ENTRIES];
   logic [63:0] key_start [ENTRIES];
   logic [63:0] ctr [ENTRIES][4];
   int          fill;
   logic [63:0] oth [4];
   logic [63:0] bytes_seen;
   logic [13:0] win_left;
   logic        win_over;

   rsp_type expected_records[$];

   function automatic rsp_type make_record(logic [1:0] k, logic [22:0] id,
                                           logic [63:0] c0, logic [63:0] c1,
                                           logic [63:0] c2, logic [63:0] c3);
      rsp_type r;
      r.record_kind = k;
      r.rec_proc_id = id;
      r.read_total = c0;
      r.write_total = c1;
      r.flush_total = c2;
      r.discard_total = c3;
      r.all_bytes = bytes_seen;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_records(input req_type it);
      bit          picked [ENTRIES];
      logic [63:0] best, p;
      int          sel;
      bit          hit;
      rsp_type     r;
      hit = 0;
      if (it.op == OP_DRAIN) begin
         foreach (picked[i]) picked[i] = 0;
         if (fill > TOP_COUNT) begin
            for (int t = 0; t < TOP_COUNT; t++) begin
               best = 0;
               sel = -1;
               for (int i = fill - 1; i >= 0; i--) begin
                  p = ctr[i][0] + (ctr[i][1] << 1);
                  if (!picked[i] && p > best) begin
                     best = p;
                     sel = i;
                  end
               end
               if (sel >= 0) begin
                  picked[sel] = 1;
                  expected_records.push_back(make_record(REC_ENTRY, key_id[sel],
                     ctr[sel][0], ctr[sel][1], ctr[sel][2], ctr[sel][3]));
               end
            end
         end
         for (int i = fill - 1; i >= 0; i--)
            if (!picked[i])
               expected_records.push_back(make_record(REC_ENTRY, key_id[i],
                  ctr[i][0], ctr[i][1], ctr[i][2], ctr[i][3]));
         if (oth[0] + oth[1] != 64'd0)
            r = make_record(REC_OTHERS, OTHERS_ID, oth[0], oth[1], oth[2], oth[3]);
         else
            r = make_record(REC_END, '0, '0, '0, '0, '0);
         r.last = 1'b1;
         expected_records.push_back(r);
         fill = 0;
         foreach (oth[k]) oth[k] = '0;
         win_left = win_len;
         win_over = 0;
      end else begin
         if (it.op == OP_ACCOUNT && it.is_internal) begin
            bytes_seen += 64'(it.xfer_bytes);
            if (en_q && !win_over && it.req_kind <= 3) begin
               for (int i = 0; i < fill && !hit; i++)
                  if (key_id[i] == it.proc_id && key_start[i] == it.proc_start) begin
                     hit = 1;
                     ctr[i][it.req_kind] += (it.req_kind == KIND_FLUSH) ? 64'd1
                                                                       : 64'(it.xfer_bytes);
                  end
               if (!hit) begin
                  if (fill < ENTRIES) begin
                     key_id[fill] = it.proc_id;
                     key_start[fill] = it.proc_start;
                     for (int k = 0; k < 4; k++) ctr[fill][k] = '0;
                     ctr[fill][it.req_kind] = 64'(it.xfer_bytes);
                     fill++;
                  end else
                     oth[it.req_kind] += 64'(it.xfer_bytes);
               end
            end
         end else if (it.op == OP_TICK) begin
            if (win_left != 0) win_left--;
            else win_over = 1;
         end
         r = make_record(REC_ACK, '0, '0, '0, '0, '0);
         r.last = 1'b1;
         expected_records.push_back(r);
      end
   endtask

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e, a;
      if (reset) begin
         en_q <= 0;
         win_len <= WINDOW_RST;
         fill = 0;
         foreach (oth[k]) oth[k] = '0;
         bytes_seen = '0;
         win_left = '0;
         win_over = 1;
         expected_records.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_ENABLE) en_q <= csr_wr_data[0];
            else if (csr_index == CSR_WINDOW)
               win_len <= (csr_wr_data > WINDOW_MAX) ? WINDOW_MAX : csr_wr_data;
         end
         if (rsp.valid && rsp.ready) begin
            a = rsp.data;
            if (expected_records.size() == 0) begin
               $error("record with no expectation waiting: %p", a);
               fail_count++;
            end else begin
               e = expected_records.pop_front();
               compare_field("record_kind", 64'(e.record_kind), 64'(a.record_kind));
               compare_field("rec_proc_id", 64'(e.rec_proc_id), 64'(a.rec_proc_id));
               compare_field("read_total", e.read_total, a.read_total);
               compare_field("write_total", e.write_total, a.write_total);
               compare_field("flush_total", e.flush_total, a.flush_total);
               compare_field("discard_total", e.discard_total, a.discard_total);
               compare_field("all_bytes", e.all_bytes, a.all_bytes);
               compare_field("last", 64'(e.last), 64'(a.last));
            end
         end
         if (req.valid && req.ready) predict_records(req.data);
      end
      records_pending = expected_records.size();
   end
endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus, idling and verdict for the per-process io accounting table
// depends on ppioa_pkg, ppioa_if, the block and ppioa_checker
`timescale 1ns / 1ps
module testbench;
   import ppioa_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [0:0]  csr_index = CSR_ENABLE;
   logic [13:0] csr_wr_data = '0;
   int          fail_count;
   int          records_pending;
   int          idle_cycles = 0;
   int          sent = 0;
   bit          calm = 0;      // no idling in the closing part
   bit          hold_rsp = 0;  // long receiver hold-off request
   bit          timed_out = 0;

   ppioa_req_if req ();
   ppioa_rsp_if rsp ();

   per_process_io_accounting_table dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   ppioa_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .records_pending(records_pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // small key pool so hits, new entries and table overflow all occur
   logic [22:0] id_pool [40];
   logic [63:0] start_pool [40];

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 0;
            n = $urandom_range(1, 7);
            repeat (n) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
      end
   end

   // watchdog: cycles with nothing accepted on either channel
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("status: fail");
         $finish;
      end
   end

   task automatic csr_write(input logic [0:0] idx, input logic [13:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // wait for every record, then the drain-length tail before touching registers
   task automatic settle();
      req.valid <= 0;
      @(posedge clock);
      while (records_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_item(input req_type it);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         n = $urandom_range(1, 7);
         repeat (n) @(posedge clock);
      end
      req.valid <= 1;
      req.data <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   function automatic req_type account_item(int slot, logic [2:0] k, logic [31:0] sz);
      req_type it;
      it = '0;
      it.op = OP_ACCOUNT;
      it.is_internal = 1;
      it.req_kind = k;
      it.xfer_bytes = sz;
      it.proc_id = id_pool[slot];
      it.proc_start = start_pool[slot];
      return it;
   endfunction

   function automatic req_type simple_item(logic [1:0] o);
      req_type it;
      it = '0;
      it.op = o;
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         it = account_item($urandom_range(0, 39), 3'($urandom_range(0, 3)),
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65535));
         if ($urandom_range(0, 15) == 0) it.req_kind = 3'($urandom_range(4, 7));
         if ($urandom_range(0, 15) == 0) it.is_internal = 0;
      end else if (r < 88) begin
         it = simple_item(OP_TICK);
      end else if (r < 92) begin
         it = simple_item(2'd3);
      end else begin
         it = simple_item(OP_DRAIN);
      end
      if (it.op != OP_ACCOUNT) begin
         // noise in unused fields
         it.is_internal = 1'($urandom);
         it.req_kind = 3'($urandom);
         it.xfer_bytes = $urandom;
         it.proc_id = 23'($urandom);
         it.proc_start = {$urandom, $urandom};
      end
      return it;
   endfunction

   initial begin
      req_type it;
      foreach (id_pool[i]) begin
         id_pool[i] = 23'($urandom);
         start_pool[i] = {$urandom, $urandom};
      end
      // extreme keys
      id_pool[0] = '0;
      start_pool[0] = '0;
      id_pool[1] = '1;
      start_pool[1] = '1;
      id_pool[2] = id_pool[3];          // same id, different start
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: window expired after reset, nothing tabled
      csr_write(CSR_ENABLE, 14'd1);
      send_item(account_item(0, 3'd0, 32'hffff_ffff));
      send_item(simple_item(2'd3));
      it = account_item(1, 3'd1, 32'd7);
      it.is_internal = 0;
      send_item(it);
      // window of length 1, drain starts it
      settle();
      csr_write(CSR_WINDOW, 14'd1);
      send_item(simple_item(OP_DRAIN));
      // hit, new entry, flush counts 1 on hit, big sizes add up in 64-bit counters
      send_item(account_item(0, 3'd0, 32'hffff_ffff));
      send_item(account_item(0, 3'd0, 32'hffff_ffff));
      send_item(account_item(1, 3'd2, 32'h1234));
      send_item(account_item(1, 3'd2, 32'h1234));
      send_item(account_item(2, 3'd3, 32'd0));
      send_item(account_item(3, 3'd1, 32'h8000_0000));
      send_item(account_item(3, 3'd5, 32'd9));
      // window of 1: expires on the second tick
      send_item(simple_item(OP_TICK));
      send_item(simple_item(OP_TICK));
      send_item(account_item(4, 3'd0, 32'd11));
      send_item(simple_item(OP_DRAIN));
      // fill past capacity so others and top-ordering engage; hold the receiver
      settle();
      csr_write(CSR_WINDOW, 14'h3fff);   // clamps to the maximum
      send_item(simple_item(OP_DRAIN));
      hold_rsp = 1;
      for (int i = 0; i < 36; i++)
         send_item(account_item(i, 3'($urandom_range(0, 1)), $urandom));
      send_item(simple_item(OP_DRAIN));
      // sender pauses until every record is back
      settle();
      csr_write(CSR_WINDOW, 14'd0);
      send_item(simple_item(OP_DRAIN));
      send_item(simple_item(OP_TICK));
      send_item(simple_item(OP_TICK));
      send_item(account_item(5, 3'd0, 32'd1));
      settle();
      csr_write(CSR_WINDOW, 14'd10000);
      csr_write(CSR_ENABLE, 14'd0);
      send_item(simple_item(OP_DRAIN));
      send_item(account_item(6, 3'd0, 32'd5));
      settle();
      csr_write(CSR_ENABLE, 14'd1);
      send_item(simple_item(OP_DRAIN));

      // random phases with register changes between them
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) calm = 1;
         for (int i = 0; i < 50; i++) send_item(random_item());
         settle();
         csr_write(CSR_WINDOW, ($urandom_range(0, 3) == 0) ? 14'd2
                                                           : 14'($urandom_range(500, 16383)));
         csr_write(CSR_ENABLE, {13'd0, ($urandom_range(0, 4) != 0)});
         send_item(simple_item(OP_DRAIN));
      end

      settle();
      if (fail_count == 0 && records_pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
